[sv/imu_burst_tilt_and_temperature_top_defines.svh]
// assertion macros for the burst tilt and temperature block
`ifndef IMU_BURST_TILT_AND_TEMPERATURE_TOP_DEFINES_SVH
`define IMU_BURST_TILT_AND_TEMPERATURE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define IMU_BTT_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define IMU_BTT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/imu_btt_pkg.sv]
package imu_btt_pkg;

   // default sizes
   localparam int BURST_BYTES_DEF  = 14;
   localparam int CORDIC_STEPS_DEF = 20;

   // field and datapath widths
   localparam int AXIS_W     = 16;
   localparam int TEMP_W     = 15;
   localparam int TILT_W     = 12;
   localparam int VEC_W      = 20;
   localparam int PHASE_W    = 28;
   localparam int NORM_W     = 17;
   localparam int ATAN_W     = 24;
   localparam int ATAN_IDX_W = 5;
   localparam int PHASE_FRAC = 24;

   // angle constants, phase has 24 fractional bits of radians
   localparam logic signed [PHASE_W-1:0] PHASE_HALF_PI = 28'sd26353589;
   localparam int                        SCALE_W       = 10;
   localparam logic [SCALE_W-1:0]        ANGLE_SCALE   = 10'd573;
   localparam logic signed [TILT_W-1:0]  TILT_AT_PI    = 12'sd1800;

   // temperature constants, divide by 34 as multiply by rounded-up 2^24/34
   localparam logic signed [AXIS_W:0]   TEMP_OFFSET      = 17'sd521;
   localparam logic signed [TEMP_W-1:0] TEMP_BASE        = 15'sd3500;
   localparam int                       TEMP_MAG_W       = 19;
   localparam logic [TEMP_MAG_W-1:0]    TEMP_RECIP       = 19'd493448;
   localparam int                       TEMP_RECIP_SHIFT = 24;
   localparam int                       TEMP_Q_W         = 14;

   // assembled sensor words
   typedef struct packed {
      logic signed [AXIS_W-1:0] x;
      logic signed [AXIS_W-1:0] y;
      logic signed [AXIS_W-1:0] z;
      logic signed [AXIS_W-1:0] t;
   } raw_burst_type;

   // launch of the angle unit
   typedef struct packed {
      logic                     start;
      logic signed [AXIS_W-1:0] axis;
      logic signed [AXIS_W-1:0] vert;
   } cordic_ctrl_type;

   // angle unit status
   typedef struct packed {
      logic                     done;
      logic signed [TILT_W-1:0] angle;
   } cordic_stat_type;

   // arctangent of 2^-i, 24 fractional bits
   function automatic logic [ATAN_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic [ATAN_W-1:0] val;
      unique case (idx)
         5'd0:    val = 24'd13176795;
         5'd1:    val = 24'd7778716;
         5'd2:    val = 24'd4110060;
         5'd3:    val = 24'd2086331;
         5'd4:    val = 24'd1047214;
         5'd5:    val = 24'd524117;
         5'd6:    val = 24'd262123;
         5'd7:    val = 24'd131069;
         5'd8:    val = 24'd65536;
         5'd9:    val = 24'd32768;
         5'd10:   val = 24'd16384;
         5'd11:   val = 24'd8192;
         5'd12:   val = 24'd4096;
         5'd13:   val = 24'd2048;
         5'd14:   val = 24'd1024;
         5'd15:   val = 24'd512;
         5'd16:   val = 24'd256;
         5'd17:   val = 24'd128;
         5'd18:   val = 24'd64;
         5'd19:   val = 24'd32;
         5'd20:   val = 24'd16;
         5'd21:   val = 24'd8;
         5'd22:   val = 24'd4;
         5'd23:   val = 24'd2;
         5'd24:   val = 24'd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

[sv/imu_burst_tilt_and_temperature_top.sv]
// Burst tilt and temperature.
// Input channel: one sensor register byte per word on req_data_byte, with
// req_burst_start marking offset zero; a word is taken at a clock edge with
// start high and busy low. Bytes 0..7 form X, Y, Z and the raw temperature
// big-endian; the remaining burst bytes are dropped.
// Bytes before the last of a burst never raise busy. The last byte raises
// busy while the CORDIC rotator normalizes the larger operand by 1..16
// one-bit shifts, pre-rotates, runs one micro-rotation per cycle and
// scales; a zero Z skips the angle iterations.
// Result channel: rsp_valid is high for one cycle, the cycle in which busy
// falls, with the raw axes, the temperature in 0.01 degC and the tilt in
// 0.1 deg. The receiver cannot stall; results are not held.
// Config: APB register 0 (angle_plane, byte address 0) picks X (1) or Y (0)
// as the horizontal axis; pready is always high.
// Reset clears the byte count and the assembled words and sets angle_plane.
`include "imu_burst_tilt_and_temperature_top_defines.svh"

module imu_burst_tilt_and_temperature_top #(
   parameter int BURST_BYTES  = imu_btt_pkg::BURST_BYTES_DEF,
   parameter int CORDIC_STEPS = imu_btt_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [7:0]                             req_data_byte,
   input  logic                                   req_burst_start,
   output logic                                   rsp_valid,
   output logic signed [imu_btt_pkg::AXIS_W-1:0]  rsp_accel_x,
   output logic signed [imu_btt_pkg::AXIS_W-1:0]  rsp_accel_y,
   output logic signed [imu_btt_pkg::AXIS_W-1:0]  rsp_accel_z,
   output logic signed [imu_btt_pkg::TEMP_W-1:0]  rsp_temperature_centi,
   output logic signed [imu_btt_pkg::TILT_W-1:0]  rsp_tilt_angle,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [2:0]                             paddr,
   input  logic [31:0]                            pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);

   // register index carried by paddr[2]
   localparam logic CSR_IDX_ANGLE_PLANE = 1'b0;

   typedef enum logic [1:0] {
      T_IDLE,
      T_LAUNCH,
      T_WAIT
   } state_type;

   state_type                    state_ff;
   logic                         rsp_valid_ff;
   logic                         plane_ff;
   logic signed [imu_btt_pkg::AXIS_W-1:0] accel_x_ff;
   logic signed [imu_btt_pkg::AXIS_W-1:0] accel_y_ff;
   logic signed [imu_btt_pkg::AXIS_W-1:0] accel_z_ff;
   logic signed [imu_btt_pkg::TEMP_W-1:0] temp_ff;
   logic signed [imu_btt_pkg::TILT_W-1:0] tilt_ff;

   logic                          accept;
   logic                          last_byte;
   logic                          csr_write;
   logic                          csr_hit;
   imu_btt_pkg::raw_burst_type    raw;
   imu_btt_pkg::cordic_ctrl_type  cordic_ctrl;
   imu_btt_pkg::cordic_stat_type  cordic_stat;
   logic signed [imu_btt_pkg::TEMP_W-1:0] temp_centi;

   assign busy   = state_ff != T_IDLE;
   assign accept = start && !busy;

   // byte assembly
   imu_btt_burst_asm #(
      .BURST_BYTES (BURST_BYTES)
   ) u_burst_asm (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .burst_start (req_burst_start),
      .raw         (raw),
      .last_byte   (last_byte)
   );

   // temperature conversion, through a registered magnitude and a registered result
   imu_btt_temp_conv u_temp_conv (
      .clock      (clock),
      .raw_temp   (raw.t),
      .temp_centi (temp_centi)
   );

   // angle unit
   assign cordic_ctrl.start = state_ff == T_LAUNCH;
   assign cordic_ctrl.axis  = plane_ff ? raw.x : raw.y;
   assign cordic_ctrl.vert  = raw.z;

   imu_btt_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .ctrl  (cordic_ctrl),
      .stat  (cordic_stat)
   );

   // config port decode, low address bits ignored
   assign pready    = 1'b1;
   assign csr_hit   = paddr[2] == CSR_IDX_ANGLE_PLANE;
   assign csr_write = psel && penable && pwrite && pready && csr_hit;
   assign prdata    = csr_hit ? {31'b0, plane_ff} : '0;

   // control sequence and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
         plane_ff     <= 1'b1;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_write) begin
            plane_ff <= pwdata[0];
         end
         unique case (state_ff)
            T_IDLE: begin
               if (accept && last_byte) begin
                  state_ff <= T_LAUNCH;
               end
            end
            T_LAUNCH: begin
               state_ff <= T_WAIT;
            end
            T_WAIT: begin
               if (cordic_stat.done) begin
                  rsp_valid_ff <= 1'b1;
                  accel_x_ff   <= raw.x;
                  accel_y_ff   <= raw.y;
                  accel_z_ff   <= raw.z;
                  temp_ff      <= temp_centi;
                  tilt_ff      <= cordic_stat.angle;
                  state_ff     <= T_IDLE;
               end
            end
            default: begin
               state_ff <= T_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_accel_x           = accel_x_ff;
   assign rsp_accel_y           = accel_y_ff;
   assign rsp_accel_z           = accel_z_ff;
   assign rsp_temperature_centi = temp_ff;
   assign rsp_tilt_angle        = tilt_ff;

   // checks
   `IMU_BTT_ASSERT_NEXT(a_rsp_single, rsp_valid_ff, !rsp_valid_ff, "result strobe held")
   `IMU_BTT_ASSERT_SAME(a_rsp_idle, rsp_valid_ff, state_ff == T_IDLE, "result while busy")
   `IMU_BTT_ASSERT_NEXT(a_last_launch, accept && last_byte, state_ff == T_LAUNCH, "no launch")
   `IMU_BTT_ASSERT_SAME(a_done_wait, cordic_stat.done, state_ff == T_WAIT, "stray angle done")

endmodule

[sv/imu_btt_burst_asm.sv]
module imu_btt_burst_asm #(
   parameter int BURST_BYTES = imu_btt_pkg::BURST_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [7:0]                  data_byte,
   input  logic                        burst_start,
   output imu_btt_pkg::raw_burst_type  raw,
   output logic                        last_byte
);

   localparam int              POS_W    = $clog2(BURST_BYTES);
   localparam logic [POS_W:0]  WORD_END = (POS_W+1)'(8);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(BURST_BYTES - 1);

   logic [POS_W-1:0]           pos_ff;
   logic [POS_W-1:0]           pos;
   logic [7:0]                 pending_ff;
   imu_btt_pkg::raw_burst_type raw_ff;
   logic                       in_words;

   // a start flag forces offset zero
   assign pos       = burst_start ? '0 : pos_ff;
   assign in_words  = {1'b0, pos} < WORD_END;
   assign last_byte = pos >= LAST_POS;
   assign raw       = raw_ff;

   // byte counter and big-endian word assembly
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         pending_ff <= '0;
         raw_ff     <= '0;
      end else if (accept) begin
         pos_ff <= last_byte ? '0 : pos + 1'b1;
         if (in_words) begin
            if (!pos[0]) begin
               pending_ff <= data_byte;
            end else begin
               unique case (pos[2:1])
                  2'd0: raw_ff.x <= {pending_ff, data_byte};
                  2'd1: raw_ff.y <= {pending_ff, data_byte};
                  2'd2: raw_ff.z <= {pending_ff, data_byte};
                  2'd3: raw_ff.t <= {pending_ff, data_byte};
               endcase
            end
         end
      end
   end

endmodule

[sv/imu_btt_temp_conv.sv]
module imu_btt_temp_conv (
   input  logic                                     clock,
   input  logic signed [imu_btt_pkg::AXIS_W-1:0]    raw_temp,
   output logic signed [imu_btt_pkg::TEMP_W-1:0]    temp_centi
);

   localparam int SUM_W  = imu_btt_pkg::AXIS_W + 1;
   localparam int PROD_W = 2 * imu_btt_pkg::TEMP_MAG_W;
   localparam int MAG_W  = imu_btt_pkg::TEMP_MAG_W;
   localparam int WIDE_W = MAG_W + 2;

   logic signed [SUM_W-1:0]   sum;
   logic signed [WIDE_W-1:0]  sum_ext;
   logic signed [WIDE_W-1:0]  scaled;
   logic [WIDE_W-1:0]         scaled_abs;
   logic [MAG_W-1:0]          mag_ff;
   logic                      neg_ff;
   logic [PROD_W-1:0]         prod;
   logic [imu_btt_pkg::TEMP_Q_W-1:0]       quot;
   logic signed [imu_btt_pkg::TEMP_W-1:0]  quot_s;
   logic signed [imu_btt_pkg::TEMP_W-1:0]  temp_ff;

   // stage one: offset, times ten, magnitude
   assign sum        = SUM_W'(raw_temp) + imu_btt_pkg::TEMP_OFFSET;
   assign sum_ext    = WIDE_W'(sum);
   assign scaled     = (sum_ext <<< 3) + (sum_ext <<< 1);
   assign scaled_abs = scaled[WIDE_W-1] ? WIDE_W'(-scaled) : WIDE_W'(scaled);

   // stage two: divide by 34 through the reciprocal, truncating toward zero
   assign prod   = PROD_W'(mag_ff) * PROD_W'(imu_btt_pkg::TEMP_RECIP);
   assign quot   = prod[imu_btt_pkg::TEMP_RECIP_SHIFT +: imu_btt_pkg::TEMP_Q_W];
   assign quot_s = {1'b0, quot};

   always_ff @(posedge clock) begin
      mag_ff  <= scaled_abs[MAG_W-1:0];
      neg_ff  <= scaled[WIDE_W-1];
      temp_ff <= neg_ff ? imu_btt_pkg::TEMP_BASE - quot_s
                        : imu_btt_pkg::TEMP_BASE + quot_s;
   end

   assign temp_centi = temp_ff;

endmodule

[sv/imu_btt_cordic.sv]
module imu_btt_cordic #(
   parameter int CORDIC_STEPS = imu_btt_pkg::CORDIC_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  imu_btt_pkg::cordic_ctrl_type  ctrl,
   output imu_btt_pkg::cordic_stat_type  stat
);

   localparam int VEC_W   = imu_btt_pkg::VEC_W;
   localparam int PHASE_W = imu_btt_pkg::PHASE_W;
   localparam int NORM_W  = imu_btt_pkg::NORM_W;
   localparam int TILT_W  = imu_btt_pkg::TILT_W;
   localparam int ATAN_W  = imu_btt_pkg::ATAN_W;
   localparam int PROD_W  = PHASE_W + imu_btt_pkg::SCALE_W;
   localparam int STEP_W  = $clog2(CORDIC_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_NORM,
      S_ROT,
      S_ITER,
      S_SCALE
   } state_type;

   state_type                  state_ff;
   logic signed [VEC_W-1:0]    x_ff;
   logic signed [VEC_W-1:0]    y_ff;
   logic [NORM_W-1:0]          mag_ff;
   logic signed [PHASE_W-1:0]  phase_ff;
   logic [STEP_W-1:0]          step_ff;
   logic                       zero_ff;
   logic                       neg_ff;
   logic                       done_ff;
   logic signed [TILT_W-1:0]   angle_ff;

   logic signed [NORM_W-1:0]   axis_w;
   logic signed [NORM_W-1:0]   vert_w;
   logic [NORM_W-1:0]          axis_abs;
   logic [NORM_W-1:0]          vert_abs;
   logic signed [VEC_W-1:0]    dx;
   logic signed [VEC_W-1:0]    dy;
   logic [ATAN_W-1:0]          atan;
   logic signed [PHASE_W-1:0]  atan_ext;
   logic [PHASE_W-1:0]         phase_abs;
   logic [PROD_W-1:0]          prod;
   logic [TILT_W-2:0]          angle_mag;
   logic signed [TILT_W-1:0]   angle_calc;

   // operand magnitudes for the normalizing shift
   assign axis_w   = NORM_W'(ctrl.axis);
   assign vert_w   = NORM_W'(ctrl.vert);
   assign axis_abs = axis_w[NORM_W-1] ? NORM_W'(-axis_w) : NORM_W'(axis_w);
   assign vert_abs = vert_w[NORM_W-1] ? NORM_W'(-vert_w) : NORM_W'(vert_w);

   // one micro-rotation: floor shifts and table angle
   assign dx       = y_ff >>> step_ff;
   assign dy       = x_ff >>> step_ff;
   assign atan     = imu_btt_pkg::atan_entry(imu_btt_pkg::ATAN_IDX_W'(step_ff));
   assign atan_ext = {{(PHASE_W-ATAN_W){1'b0}}, atan};

   // phase to tenths of a degree, truncating toward zero
   assign phase_abs  = phase_ff[PHASE_W-1] ? PHASE_W'(-phase_ff) : PHASE_W'(phase_ff);
   assign prod       = PROD_W'(phase_abs) * PROD_W'(imu_btt_pkg::ANGLE_SCALE);
   assign angle_mag  = prod[imu_btt_pkg::PHASE_FRAC +: (TILT_W-1)];
   assign angle_calc = phase_ff[PHASE_W-1] ? -$signed({1'b0, angle_mag})
                                           : $signed({1'b0, angle_mag});

   // sequencer: normalize, pre-rotate, iterate, scale
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (ctrl.start) begin
                  x_ff     <= VEC_W'(ctrl.axis);
                  y_ff     <= VEC_W'(ctrl.vert);
                  mag_ff   <= (axis_abs > vert_abs) ? axis_abs : vert_abs;
                  zero_ff  <= ctrl.vert == '0;
                  neg_ff   <= ctrl.axis[imu_btt_pkg::AXIS_W-1];
                  state_ff <= S_NORM;
               end
            end
            S_NORM: begin
               if (zero_ff) begin
                  state_ff <= S_SCALE;
               end else if (!mag_ff[NORM_W-1]) begin
                  x_ff   <= x_ff <<< 1;
                  y_ff   <= y_ff <<< 1;
                  mag_ff <= mag_ff << 1;
               end else begin
                  state_ff <= S_ROT;
               end
            end
            S_ROT: begin
               // left half plane folds into the right by a quarter turn
               if (x_ff[VEC_W-1]) begin
                  if (y_ff > 0) begin
                     x_ff     <= y_ff;
                     y_ff     <= -x_ff;
                     phase_ff <= imu_btt_pkg::PHASE_HALF_PI;
                  end else begin
                     x_ff     <= -y_ff;
                     y_ff     <= x_ff;
                     phase_ff <= -imu_btt_pkg::PHASE_HALF_PI;
                  end
               end else begin
                  phase_ff <= '0;
               end
               step_ff  <= '0;
               state_ff <= S_ITER;
            end
            S_ITER: begin
               if (y_ff[VEC_W-1]) begin
                  x_ff     <= x_ff - dx;
                  y_ff     <= y_ff + dy;
                  phase_ff <= phase_ff - atan_ext;
               end else begin
                  x_ff     <= x_ff + dx;
                  y_ff     <= y_ff - dy;
                  phase_ff <= phase_ff + atan_ext;
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == LAST_STEP) begin
                  state_ff <= S_SCALE;
               end
            end
            S_SCALE: begin
               // zero vertical axis gives an exact angle
               if (zero_ff) begin
                  angle_ff <= neg_ff ? imu_btt_pkg::TILT_AT_PI : '0;
               end else begin
                  angle_ff <= angle_calc;
               end
               done_ff  <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign stat.done  = done_ff;
   assign stat.angle = angle_ff;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   // run sizing
   localparam int RANDOM_WORDS   = 900;
   localparam int SETTLE_CYCLES  = 64;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int BURST_LEN      = 14;
   localparam int ITERATIONS     = 20;
   localparam logic [2:0] ANGLE_PLANE_ADDR = 3'd0;

   // angle math constants, phase in 24 fractional bits of radians
   localparam longint HALF_PI_Q24  = 64'sd26353589;
   localparam longint DECI_DEG_PER_RAD = 64'sd573;
   localparam int     DECI_DEG_AT_PI   = 1800;
   localparam int     TEMP_BIAS  = 521;
   localparam int     TEMP_MUL   = 10;
   localparam int     TEMP_DIV   = 34;
   localparam int     TEMP_ZERO  = 3500;

   // one expected sensor reading
   typedef struct packed {
      logic signed [imu_btt_pkg::AXIS_W-1:0] ax;
      logic signed [imu_btt_pkg::AXIS_W-1:0] ay;
      logic signed [imu_btt_pkg::AXIS_W-1:0] az;
      logic signed [imu_btt_pkg::TEMP_W-1:0] temp;
      logic signed [imu_btt_pkg::TILT_W-1:0] tilt;
   } reading_type;

   // burst assembler and tilt predictor with its queue of readings
   class tilt_scoreboard;
      bit [3:0]       position;
      bit [7:0]       high_byte;
      bit [15:0]      word_x, word_y, word_z, word_t;
      bit             plane;
      longint         arctan_q24[ITERATIONS];
      reading_type    readings[$];
      int             errors;

      function new();
         arctan_q24 = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                        131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                        256, 128, 64, 32};
         plane = 1'b1;
      endfunction

      function int pending();
         return readings.size();
      endfunction

      // vectoring cordic on normalized operands
      function int tilt_of(int a, int z);
         longint vx, vy, m, t, phase, prod, dx, dy, mag;
         if (z == 0) begin
            return (a < 0) ? DECI_DEG_AT_PI : 0;
         end
         vx = a;
         vy = z;
         m = (vx < 0) ? -vx : vx;
         if (((vy < 0) ? -vy : vy) > m) begin
            m = (vy < 0) ? -vy : vy;
         end
         while (m < 65536) begin
            m = m * 2;
            vx = vx * 2;
            vy = vy * 2;
         end
         // fold the left half plane onto the right one
         phase = 0;
         if (vx < 0) begin
            if (vy > 0) begin
               t = vx; vx = vy; vy = -t;
               phase = HALF_PI_Q24;
            end else begin
               t = vx; vx = -vy; vy = t;
               phase = -HALF_PI_Q24;
            end
         end
         for (int i = 0; i < ITERATIONS; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy < 0) begin
               vx = vx - dx;
               vy = vy + dy;
               phase = phase - arctan_q24[i];
            end else begin
               vx = vx + dx;
               vy = vy - dy;
               phase = phase + arctan_q24[i];
            end
         end
         // scale to tenths of a degree, truncating toward zero
         prod = phase * DECI_DEG_PER_RAD;
         mag = ((prod < 0) ? -prod : prod) >>> 24;
         return (prod < 0) ? -int'(mag) : int'(mag);
      endfunction

      // note one accepted burst byte
      function void take_byte(bit [7:0] b, bit flag);
         bit [3:0] p;
         reading_type r;
         int t_raw, horiz;
         if (flag) begin
            position = 4'd0;
         end
         p = position;
         if (p < 8) begin
            if (!p[0]) begin
               high_byte = b;
            end else begin
               case (p >> 1)
                  0: word_x = {high_byte, b};
                  1: word_y = {high_byte, b};
                  2: word_z = {high_byte, b};
                  default: word_t = {high_byte, b};
               endcase
            end
         end
         if (p >= BURST_LEN - 1) begin
            position = 4'd0;
            t_raw = $signed(word_t);
            horiz = plane ? $signed(word_x) : $signed(word_y);
            r.ax = word_x;
            r.ay = word_y;
            r.az = word_z;
            r.temp = imu_btt_pkg::TEMP_W'(((t_raw + TEMP_BIAS) * TEMP_MUL) / TEMP_DIV
                                          + TEMP_ZERO);
            r.tilt = imu_btt_pkg::TILT_W'(tilt_of(horiz, $signed(word_z)));
            readings.push_back(r);
         end else begin
            position = p + 4'd1;
         end
      endfunction

      // compare one result word with the oldest reading
      function void check_reading(reading_type got);
         reading_type want;
         if (readings.size() == 0) begin
            $display("%0t: unexpected result word ax=%0d ay=%0d az=%0d temp=%0d tilt=%0d",
                     $time, got.ax, got.ay, got.az, got.temp, got.tilt);
            errors++;
            return;
         end
         want = readings.pop_front();
         if (got.ax !== want.ax) begin
            $display("%0t: accel_x expected %0d actual %0d", $time, want.ax, got.ax);
            errors++;
         end
         if (got.ay !== want.ay) begin
            $display("%0t: accel_y expected %0d actual %0d", $time, want.ay, got.ay);
            errors++;
         end
         if (got.az !== want.az) begin
            $display("%0t: accel_z expected %0d actual %0d", $time, want.az, got.az);
            errors++;
         end
         if (got.temp !== want.temp) begin
            $display("%0t: temperature expected %0d actual %0d", $time, want.temp, got.temp);
            errors++;
         end
         if (got.tilt !== want.tilt) begin
            $display("%0t: tilt expected %0d actual %0d", $time, want.tilt, got.tilt);
            errors++;
         end
      endfunction
   endclass

   logic                                  clock;
   logic                                  reset;
   logic                                  start;
   logic                                  busy;
   logic [7:0]                            req_data_byte;
   logic                                  req_burst_start;
   logic                                  rsp_valid;
   logic signed [imu_btt_pkg::AXIS_W-1:0] rsp_accel_x;
   logic signed [imu_btt_pkg::AXIS_W-1:0] rsp_accel_y;
   logic signed [imu_btt_pkg::AXIS_W-1:0] rsp_accel_z;
   logic signed [imu_btt_pkg::TEMP_W-1:0] rsp_temperature_centi;
   logic signed [imu_btt_pkg::TILT_W-1:0] rsp_tilt_angle;
   logic                                  psel;
   logic                                  penable;
   logic                                  pwrite;
   logic [2:0]                            paddr;
   logic [31:0]                           pwdata;
   logic [31:0]                           prdata;
   logic                                  pready;

   tilt_scoreboard sb;
   int             cycles;
   int             words_sent;
   int             run_left;
   bit             need_flag;

   imu_burst_tilt_and_temperature_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_data_byte         (req_data_byte),
      .req_burst_start       (req_burst_start),
      .rsp_valid             (rsp_valid),
      .rsp_accel_x           (rsp_accel_x),
      .rsp_accel_y           (rsp_accel_y),
      .rsp_accel_z           (rsp_accel_z),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_tilt_angle        (rsp_tilt_angle),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // result monitor, the receiver never stalls
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && sb != null) begin
         sb.check_reading({rsp_accel_x, rsp_accel_y, rsp_accel_z,
                           rsp_temperature_centi, rsp_tilt_angle});
      end
   end

   // drop start, with noise on the data lines
   task automatic pause(input int n);
      start <= 1'b0;
      req_data_byte <= 8'($urandom_range(0, 255));
      req_burst_start <= 1'($urandom_range(0, 1));
      repeat (n) @(posedge clock);
   endtask

   // offer one word and wait until it is taken
   task automatic send_byte(input bit [7:0] b, input bit flag);
      if (run_left == 0) begin
         run_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            pause($urandom_range(1, 6));
         end
      end
      run_left--;
      start <= 1'b1;
      req_data_byte <= b;
      req_burst_start <= flag;
      do @(posedge clock); while (busy !== 1'b0);
      sb.take_byte(b, flag);
      words_sent++;
   endtask

   // bytes 0..upto-1 of a burst; bytes past the words are filler
   task automatic send_burst(input bit [15:0] x, input bit [15:0] y, input bit [15:0] z,
                             input bit [15:0] t, input bit flagged, input int upto);
      bit [63:0] words;
      words = {x, y, z, t};
      for (int i = 0; i < upto; i++) begin
         send_byte((i < 8) ? words[63 - 8*i -: 8] : 8'($urandom_range(0, 255)),
                   flagged && i == 0);
      end
   endtask

   // wait for all readings, then for the block to settle
   task automatic quiesce();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb access to the plane register; a read is checked against the shadow
   task automatic csr_access(input bit write, input bit value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= ANGLE_PLANE_ADDR;
      pwdata <= {31'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (write) begin
         sb.plane = value;
      end else if (prdata !== {31'd0, sb.plane}) begin
         $display("%0t: angle_plane read expected %0d actual %0h", $time, sb.plane, prdata);
         sb.errors++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // axis word with a bias toward extremes, zero and small magnitudes
   function automatic bit [15:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4, 5: return 16'($urandom_range(0, 511) - 256);
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic bit [15:0] pick_vertical();
      if ($urandom_range(0, 5) == 0) begin
         return 16'h0000;
      end
      return pick_word();
   endfunction

   // one random stretch: mostly whole bursts, some broken ones and noise
   task automatic random_burst();
      int kind;
      int n;
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
         send_burst(pick_word(), pick_word(), pick_vertical(), pick_word(),
                    need_flag ? 1'b1 : 1'($urandom_range(0, 1)), BURST_LEN);
         need_flag = 1'b0;
      end else if (kind == 7) begin
         send_burst(pick_word(), pick_word(), pick_vertical(), pick_word(), 1'b1,
                    $urandom_range(1, BURST_LEN - 1));
         need_flag = 1'b1;
      end else if (kind == 8) begin
         n = $urandom_range(1, 6);
         repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         need_flag = 1'b1;
      end else begin
         send_burst(pick_word(), pick_word(), pick_vertical(), pick_word(), 1'b1,
                    BURST_LEN);
         need_flag = 1'b0;
      end
   endtask

   // main sequence
   initial begin
      sb = new();
      cycles = 0;
      words_sent = 0;
      run_left = 0;
      need_flag = 1'b1;
      reset = 1'b1;
      start = 1'b0;
      req_data_byte = 8'd0;
      req_burst_start = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = 3'd0;
      pwdata = 32'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // plane comes out of reset as one
      csr_access(1'b0, 1'b0);

      // negative x with zero z, coldest temperature
      send_burst(16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 1'b1, BURST_LEN);
      // burst cut short, then restarted by the flag
      send_burst(16'h1234, 16'hA5A5, 16'h5A5A, 16'h0F0F, 1'b1, 3);
      // both operands zero, hottest temperature
      send_burst(16'h0000, 16'h8000, 16'h0000, 16'h7FFF, 1'b1, BURST_LEN);
      // back to back without a flag
      send_burst(16'h7FFF, 16'h0001, 16'h8000, 16'hFFFF, 1'b0, BURST_LEN);
      quiesce();

      // random phases alternating the plane
      words_sent = 0;
      for (int phase = 0; phase < 6; phase++) begin
         csr_access(1'b1, phase[0] ? 1'b1 : 1'b0);
         csr_access(1'b0, 1'b0);
         while (words_sent < (phase + 1) * (RANDOM_WORDS / 6)) begin
            random_burst();
         end
         quiesce();
      end

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
